// ===== src/gwsd_pkg.sv =====
// Shared types and constants for the work/sleep duty-cycle controller.
// Depends on nothing; imported by gwsd_core and the top level.
package gwsd_pkg;

    // event codes carried by the operation field
    localparam logic [3:0] OP_TICK          = 4'd0;
    localparam logic [3:0] OP_SET_MACHINE   = 4'd1;
    localparam logic [3:0] OP_TOGGLE_MACH   = 4'd2;
    localparam logic [3:0] OP_SET_APP       = 4'd3;
    localparam logic [3:0] OP_SET_LOCK      = 4'd4;
    localparam logic [3:0] OP_SET_CHARGING  = 4'd5;
    localparam logic [3:0] OP_SET_CHG_DONE  = 4'd6;
    localparam logic [3:0] OP_RESTART_WORK  = 4'd7;
    localparam logic [3:0] OP_RESYNC_RUN    = 4'd8;

    // reported status codes
    localparam logic [1:0] ST_WORK      = 2'd0;
    localparam logic [1:0] ST_STANDBY   = 2'd1;
    localparam logic [1:0] ST_CHARGING  = 2'd2;
    localparam logic [1:0] ST_CHG_DONE  = 2'd3;

    // configuration register indexes and reset values
    localparam logic       REG_WORK_PERIOD  = 1'b0;
    localparam logic       REG_SLEEP_PERIOD = 1'b1;
    localparam logic [15:0] PERIOD_RESET    = 16'd1000;

    // one result item
    typedef struct packed {
        logic       run_started;
        logic       run_stopped;
        logic       mode_changed;
        logic       new_mode;
        logic       machine_turned_on;
        logic       machine_turned_off;
        logic [1:0] reported_status;
        logic       power_answer;
    } t_result;

endpackage

// ===== src/gwsd_core.sv =====
// Controller state and the combinational event step that updates it.
// Depends on gwsd_pkg; instantiated by gated_work_sleep_duty_cycler_unit.
module gwsd_core
    import gwsd_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [3:0]    i_operation,
    input  logic          i_flag_value,
    input  logic [15:0]   i_work_period,
    input  logic [15:0]   i_sleep_period,
    output t_result       o_result
);

    localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam logic [CW-1:0] TMAX = CW'({TIMER_BITS{1'b1}});

    logic                  r_sleep_mode, n_sleep_mode;
    logic                  r_machine_on, n_machine_on;
    logic                  r_app_on, n_app_on;
    logic                  r_locked, n_locked;
    logic                  r_charging, n_charging;
    logic                  r_charge_done, n_charge_done;
    logic                  r_run_active, n_run_active;
    logic [TIMER_BITS-1:0] r_work_rem, n_work_rem;
    logic                  r_work_run, n_work_run;
    logic [TIMER_BITS-1:0] r_sleep_rem, n_sleep_rem;
    logic                  r_sleep_run, n_sleep_run;

    logic [CW-1:0]         work_ext, sleep_ext;
    logic [TIMER_BITS-1:0] work_load, sleep_load;

    // period saturated to the timer width
    always_comb begin
        work_ext   = CW'(i_work_period);
        sleep_ext  = CW'(i_sleep_period);
        work_load  = (work_ext > TMAX) ? TMAX[TIMER_BITS-1:0] : work_ext[TIMER_BITS-1:0];
        sleep_load = (sleep_ext > TMAX) ? TMAX[TIMER_BITS-1:0] : sleep_ext[TIMER_BITS-1:0];
    end

    // event step: mirrors the ordered flag updates of one event
    always_comb begin
        logic gated, w_exp, s_exp, target, s;
        logic p_start, p_stop, p_mode, on_p, off_p, answer;
        n_sleep_mode  = r_sleep_mode;
        n_machine_on  = r_machine_on;
        n_app_on      = r_app_on;
        n_locked      = r_locked;
        n_charging    = r_charging;
        n_charge_done = r_charge_done;
        n_run_active  = r_run_active;
        n_work_rem    = r_work_rem;
        n_work_run    = r_work_run;
        n_sleep_rem   = r_sleep_rem;
        n_sleep_run   = r_sleep_run;
        p_start = 1'b0;
        p_stop  = 1'b0;
        p_mode  = 1'b0;
        on_p    = 1'b0;
        off_p   = 1'b0;
        answer  = 1'b0;
        w_exp   = 1'b0;
        s_exp   = 1'b0;
        target  = 1'b0;
        s       = 1'b0;
        gated   = !r_machine_on || !r_app_on || r_locked;

        case (i_operation)
            OP_TICK: begin
                if (r_work_run) begin
                    if (r_work_rem <= TIMER_BITS'(1)) begin
                        w_exp      = 1'b1;
                        n_work_rem = '0;
                        n_work_run = 1'b0;
                    end else begin
                        n_work_rem = r_work_rem - TIMER_BITS'(1);
                    end
                end
                if (r_sleep_run) begin
                    if (r_sleep_rem <= TIMER_BITS'(1)) begin
                        s_exp       = 1'b1;
                        n_sleep_rem = '0;
                        n_sleep_run = 1'b0;
                    end else begin
                        n_sleep_rem = r_sleep_rem - TIMER_BITS'(1);
                    end
                end
                // work expiry first: enter sleep, start sleep timer
                if (w_exp && !gated) begin
                    if (!n_sleep_mode) begin
                        n_sleep_mode = 1'b1;
                        p_mode       = 1'b1;
                    end
                    s = n_machine_on && n_app_on && !n_locked && !n_sleep_mode;
                    if (s != n_run_active) begin
                        n_run_active = s;
                        if (s) p_start = 1'b1;
                        else   p_stop  = 1'b1;
                    end
                    n_sleep_rem = sleep_load;
                    n_sleep_run = 1'b1;
                end
                // then sleep expiry: back to work, restart work timer
                if (s_exp && !gated) begin
                    if (n_sleep_mode) begin
                        n_sleep_mode = 1'b0;
                        p_mode       = 1'b1;
                    end
                    s = n_machine_on && n_app_on && !n_locked && !n_sleep_mode;
                    if (s != n_run_active) begin
                        n_run_active = s;
                        if (s) p_start = 1'b1;
                        else   p_stop  = 1'b1;
                    end
                    n_work_rem = work_load;
                    n_work_run = 1'b1;
                end
            end
            OP_SET_MACHINE, OP_TOGGLE_MACH: begin
                target = (i_operation == OP_SET_MACHINE) ? i_flag_value : !r_machine_on;
                if (target == r_machine_on) begin
                    s = r_machine_on && r_app_on && !r_locked && !r_sleep_mode;
                    if (s != r_run_active) begin
                        n_run_active = s;
                        if (s) p_start = 1'b1;
                        else   p_stop  = 1'b1;
                    end
                end else if (target) begin
                    // switched on: no resync, no timer
                    n_machine_on = 1'b1;
                    on_p         = 1'b1;
                end else begin
                    n_machine_on = 1'b0;
                    n_work_rem   = '0;
                    n_work_run   = 1'b0;
                    n_sleep_rem  = '0;
                    n_sleep_run  = 1'b0;
                    if (r_run_active) begin
                        n_run_active = 1'b0;
                        p_stop       = 1'b1;
                    end
                    off_p = 1'b1;
                end
                answer = n_machine_on;
            end
            OP_SET_APP: begin
                if (r_app_on == i_flag_value) begin
                    s = r_machine_on && r_app_on && !r_locked && !r_sleep_mode;
                    if (s != r_run_active) begin
                        n_run_active = s;
                        if (s) p_start = 1'b1;
                        else   p_stop  = 1'b1;
                    end
                end else begin
                    n_app_on = i_flag_value;
                    if (i_flag_value && r_machine_on && !r_locked) begin
                        if (r_sleep_mode) begin
                            n_sleep_mode = 1'b0;
                            p_mode       = 1'b1;
                        end
                        if (!r_run_active) begin
                            n_run_active = 1'b1;
                            p_start      = 1'b1;
                        end
                        n_work_rem = work_load;
                        n_work_run = 1'b1;
                    end else begin
                        n_work_rem  = '0;
                        n_work_run  = 1'b0;
                        n_sleep_rem = '0;
                        n_sleep_run = 1'b0;
                        s = r_machine_on && i_flag_value && !r_locked && !r_sleep_mode;
                        if (s != r_run_active) begin
                            n_run_active = s;
                            if (s) p_start = 1'b1;
                            else   p_stop  = 1'b1;
                        end
                    end
                end
                answer = n_app_on;
            end
            OP_SET_LOCK: begin
                if (r_locked != i_flag_value) begin
                    n_locked = i_flag_value;
                    if (i_flag_value) begin
                        n_work_rem  = '0;
                        n_work_run  = 1'b0;
                        n_sleep_rem = '0;
                        n_sleep_run = 1'b0;
                    end else if (r_machine_on && r_app_on) begin
                        if (r_sleep_mode) begin
                            n_sleep_mode = 1'b0;
                            p_mode       = 1'b1;
                        end
                        n_work_rem = work_load;
                        n_work_run = 1'b1;
                    end
                    s = n_machine_on && n_app_on && !n_locked && !n_sleep_mode;
                    if (s != n_run_active) begin
                        n_run_active = s;
                        if (s) p_start = 1'b1;
                        else   p_stop  = 1'b1;
                    end
                end
            end
            OP_SET_CHARGING: begin
                n_charging = i_flag_value;
            end
            OP_SET_CHG_DONE: begin
                n_charge_done = i_flag_value;
            end
            OP_RESTART_WORK: begin
                if (!gated) begin
                    if (r_sleep_mode) begin
                        n_sleep_mode = 1'b0;
                        p_mode       = 1'b1;
                    end
                    if (!r_run_active) begin
                        n_run_active = 1'b1;
                        p_start      = 1'b1;
                    end
                    n_work_rem = work_load;
                    n_work_run = 1'b1;
                end
            end
            OP_RESYNC_RUN: begin
                s = r_machine_on && r_app_on && !r_locked && !r_sleep_mode;
                if (s != r_run_active) begin
                    n_run_active = s;
                    if (s) p_start = 1'b1;
                    else   p_stop  = 1'b1;
                end
            end
            default: begin
            end
        endcase

        o_result.run_started        = p_start;
        o_result.run_stopped        = p_stop;
        o_result.mode_changed       = p_mode;
        o_result.new_mode           = n_sleep_mode;
        o_result.machine_turned_on  = on_p;
        o_result.machine_turned_off = off_p;
        o_result.power_answer       = answer;
        // status precedence: charge done, charging, then work or standby
        if (n_charge_done) begin
            o_result.reported_status = ST_CHG_DONE;
        end else if (n_charging) begin
            o_result.reported_status = ST_CHARGING;
        end else if (n_machine_on && n_app_on && !n_locked && !n_sleep_mode) begin
            o_result.reported_status = ST_WORK;
        end else begin
            o_result.reported_status = ST_STANDBY;
        end
    end

    // state registers, updated once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sleep_mode  <= 1'b0;
            r_machine_on  <= 1'b1;
            r_app_on      <= 1'b1;
            r_locked      <= 1'b0;
            r_charging    <= 1'b0;
            r_charge_done <= 1'b0;
            r_run_active  <= 1'b0;
            r_work_rem    <= '0;
            r_work_run    <= 1'b0;
            r_sleep_rem   <= '0;
            r_sleep_run   <= 1'b0;
        end else if (i_fire) begin
            r_sleep_mode  <= n_sleep_mode;
            r_machine_on  <= n_machine_on;
            r_app_on      <= n_app_on;
            r_locked      <= n_locked;
            r_charging    <= n_charging;
            r_charge_done <= n_charge_done;
            r_run_active  <= n_run_active;
            r_work_rem    <= n_work_rem;
            r_work_run    <= n_work_run;
            r_sleep_rem   <= n_sleep_rem;
            r_sleep_run   <= n_sleep_run;
        end
    end

    // a stopped timer always holds a cleared count
    a_work_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_work_run |-> (r_work_rem == '0))
        else $error("work timer stopped with nonzero count");
    a_sleep_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sleep_run |-> (r_sleep_rem == '0))
        else $error("sleep timer stopped with nonzero count");
    // run is never left active once its conditions are gone
    a_run_implies_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_active |-> (r_machine_on && r_app_on && !r_locked && !r_sleep_mode))
        else $error("run active while gated or asleep");

endmodule

// ===== src/gated_work_sleep_duty_cycler_unit.sv =====
// Top level of the work/sleep duty-cycle controller: handshakes, input and
// result registers, period registers. Depends on gwsd_pkg and gwsd_core.
//
//  channel  direction  handshake          payload
//  -------  ---------  -----------------  -----------------------------------
//  event    in         i_valid / o_stall  i_operation, i_flag_value
//  result   out        o_valid / i_stall  run/mode/machine pulses, status, answer
//  config   in         APB psel/penable   paddr, pwdata -> prdata
//
// One item per clock sustained while the result side does not stall; each item
// passes the input register, then the event step into the result register. The
// step is a few flag updates and two TIMER_BITS decrements side by side. A stall
// at the result side holds the result register, then the input register; o_stall
// rises only when both are full. Reset is synchronous; periods return to 1000.
module gated_work_sleep_duty_cycler_unit
    import gwsd_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_operation,
    input  logic        i_flag_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_run_started,
    output logic        o_run_stopped,
    output logic        o_mode_changed,
    output logic        o_new_mode,
    output logic        o_machine_turned_on,
    output logic        o_machine_turned_off,
    output logic [1:0]  o_reported_status,
    output logic        o_power_answer,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        r_in_valid;
    logic [3:0]  r_operation;
    logic        r_flag_value;
    logic        r_out_valid;
    t_result     r_result;
    t_result     step_result;
    logic [15:0] r_work_period;
    logic [15:0] r_sleep_period;
    logic        fire;
    logic        in_take;

    // step runs when the result register is free or being drained
    assign fire    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !fire;
    assign in_take = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_operation  <= i_operation;
            r_flag_value <= i_flag_value;
        end
    end

    gwsd_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_operation    (r_operation),
        .i_flag_value   (r_flag_value),
        .i_work_period  (r_work_period),
        .i_sleep_period (r_sleep_period),
        .o_result       (step_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= step_result;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_run_started        = r_result.run_started;
    assign o_run_stopped        = r_result.run_stopped;
    assign o_mode_changed       = r_result.mode_changed;
    assign o_new_mode           = r_result.new_mode;
    assign o_machine_turned_on  = r_result.machine_turned_on;
    assign o_machine_turned_off = r_result.machine_turned_off;
    assign o_reported_status    = r_result.reported_status;
    assign o_power_answer       = r_result.power_answer;

    // period registers, word at byte address 0 and 4
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work_period  <= PERIOD_RESET;
            r_sleep_period <= PERIOD_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_WORK_PERIOD) begin
                r_work_period <= pwdata[15:0];
            end else begin
                r_sleep_period <= pwdata[15:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SLEEP_PERIOD) ? {16'd0, r_sleep_period}
                                                   : {16'd0, r_work_period};

    // work status can only be reported in work mode
    a_status_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_reported_status == ST_WORK) |-> !o_new_mode)
        else $error("work status reported in sleep mode");
    // a single event never switches the machine both ways
    a_machine_pulses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_machine_turned_on && o_machine_turned_off))
        else $error("machine on and off pulses together");

endmodule
